// ===== src/rrcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rise-rate cadence detector package
// Widths, register indexes, reset values and the types shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package rrcd_pkg;

    localparam int DIST_W    = 16;
    localparam int TIME_W    = 17;
    localparam int THR_W     = 16;
    localparam int CONFIRM_W = 4;
    localparam int HOLD_W    = 8;
    localparam int IVL_W     = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int LIMIT_W   = THR_W + TIME_W;
    // Distance difference times 15 needs 4 more bits than the signed difference.
    localparam int RISE_W    = DIST_W + 1 + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_IVL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_IVL       = 3'd5;

    localparam logic [THR_W-1:0]     RST_RISE_THRESHOLD = 16'd128;
    localparam logic [CONFIRM_W-1:0] RST_CONFIRM_COUNT  = 4'd2;
    localparam logic [HOLD_W-1:0]    RST_HOLD_COUNT     = 8'd10;
    localparam logic [TIME_W-1:0]    RST_MAX_GAP        = 17'd300;
    localparam logic [IVL_W-1:0]     RST_NORMAL_IVL     = 16'd60;
    localparam logic [IVL_W-1:0]     RST_FAST_IVL       = 16'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GAP,
        S_MUL,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic gap;
        logic mult;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/rrcd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one distance sample with its time stamp.
// ----------------------------------------------------------------------------
interface rrcd_in_if;

    logic        valid;
    logic        ready;
    logic [15:0] dist_mm;
    logic        read_ok;
    logic [16:0] time_s;

    modport source (output valid, output dist_mm, output read_ok, output time_s,
                    input ready);
    modport sink   (input valid, input dist_mm, input read_ok, input time_s,
                    output ready);

endinterface

`default_nettype wire

// ===== src/rrcd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Report channel
// Valid/ready channel that carries the mode report made for each sample.
// ----------------------------------------------------------------------------
interface rrcd_out_if;

    logic        valid;
    logic        ready;
    logic        fast_mode;
    logic        rate_evaluated;
    logic        rate_qualifies;
    logic        mode_changed;
    logic [15:0] interval_s;

    modport source (output valid, output fast_mode, output rate_evaluated,
                    output rate_qualifies, output mode_changed, output interval_s,
                    input ready);
    modport sink   (input valid, input fast_mode, input rate_evaluated,
                    input rate_qualifies, input mode_changed, input interval_s,
                    output ready);

endinterface

`default_nettype wire

// ===== src/rrcd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rise-rate cadence detector controller
// Steps each accepted sample through gap check, multiply and commit.
// ----------------------------------------------------------------------------
module rrcd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rrcd_pkg::t_dp_stat i_stat,
    output rrcd_pkg::t_dp_cmd      o_cmd
);
    import rrcd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_GAP;
                end
            end
            S_GAP:  n_state = S_MUL;
            S_MUL:  n_state = S_COMMIT;
            S_COMMIT: begin
                // The report register must be free before the state is updated.
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.gap      = 1'b0;
        o_cmd.mult     = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_GAP:    o_cmd.gap    = 1'b1;
            S_MUL:    o_cmd.mult   = 1'b1;
            S_COMMIT: o_cmd.commit = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/rrcd_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rise-rate cadence detector datapath
// Holds the registers, last sample and counters, forms the rate compare and
// keeps the report register.
// ----------------------------------------------------------------------------
module rrcd_dp #(
    parameter int DAY_SECONDS = 86400
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rrcd_pkg::t_dp_cmd                  i_cmd,
    output rrcd_pkg::t_dp_stat                      o_stat,
    input  wire logic [rrcd_pkg::DIST_W-1:0]        i_dist_mm,
    input  wire logic                               i_read_ok,
    input  wire logic [rrcd_pkg::TIME_W-1:0]        i_time_s,
    input  wire logic                               i_cfg_we,
    input  wire logic [rrcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rrcd_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_fast_mode,
    output logic                                    o_rate_evaluated,
    output logic                                    o_rate_qualifies,
    output logic                                    o_mode_changed,
    output logic [rrcd_pkg::IVL_W-1:0]              o_interval_s
);
    import rrcd_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0]     r_cfg_thr;
    logic [CONFIRM_W-1:0] r_cfg_confirm;
    logic [HOLD_W-1:0]    r_cfg_hold;
    logic [TIME_W-1:0]    r_cfg_gap;
    logic [IVL_W-1:0]     r_cfg_norm_ivl;
    logic [IVL_W-1:0]     r_cfg_fast_ivl;

    // Captured sample.
    logic [DIST_W-1:0]    r_smp_dist;
    logic                 r_smp_ok;
    logic [TIME_W-1:0]    r_smp_time;

    // Detector state.
    logic [DIST_W-1:0]    r_last_dist;
    logic [TIME_W-1:0]    r_last_time;
    logic                 r_have_last;
    logic [CONFIRM_W-1:0] r_rise_cnt;
    logic [HOLD_W-1:0]    r_quiet_cnt;
    logic                 r_fast;

    // Intermediate results.
    logic                 r_gap_ok;
    logic [TIME_W-1:0]    r_elapsed;
    logic [DIST_W:0]      r_diff;
    logic [LIMIT_W-1:0]   r_limit;
    logic [RISE_W-1:0]    r_rise15;

    // Report register.
    logic                 r_out_valid;
    logic                 r_out_fast;
    logic                 r_out_eval;
    logic                 r_out_qual;
    logic                 r_out_chg;
    logic [IVL_W-1:0]     r_out_ivl;

    logic [TIME_W:0]      w_raw;
    logic [TIME_W:0]      w_wrap;
    logic                 w_in_gap;
    logic [DIST_W:0]      w_diff;
    logic [RISE_W-1:0]    w_diff_ext;
    logic [RISE_W-1:0]    w_x15;
    logic                 w_qual;
    logic [CONFIRM_W-1:0] n_rise_cnt;
    logic [HOLD_W-1:0]    n_quiet_cnt;
    logic [HOLD_W-1:0]    w_quiet_inc;
    logic                 n_fast;

    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thr      <= RST_RISE_THRESHOLD;
            r_cfg_confirm  <= RST_CONFIRM_COUNT;
            r_cfg_hold     <= RST_HOLD_COUNT;
            r_cfg_gap      <= RST_MAX_GAP;
            r_cfg_norm_ivl <= RST_NORMAL_IVL;
            r_cfg_fast_ivl <= RST_FAST_IVL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RISE_THRESHOLD: r_cfg_thr      <= i_cfg_data[THR_W-1:0];
                CFG_CONFIRM_COUNT:  r_cfg_confirm  <= i_cfg_data[CONFIRM_W-1:0];
                CFG_HOLD_COUNT:     r_cfg_hold     <= i_cfg_data[HOLD_W-1:0];
                CFG_MAX_GAP:        r_cfg_gap      <= i_cfg_data[TIME_W-1:0];
                CFG_NORMAL_IVL:     r_cfg_norm_ivl <= i_cfg_data[IVL_W-1:0];
                CFG_FAST_IVL:       r_cfg_fast_ivl <= i_cfg_data[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Elapsed time wraps once at the end of the day.
    assign w_raw    = {1'b0, r_smp_time} - {1'b0, r_last_time};
    assign w_wrap   = w_raw[TIME_W] ? (w_raw + (TIME_W+1)'(DAY_SECONDS)) : w_raw;
    assign w_in_gap = r_smp_ok && r_have_last && !w_wrap[TIME_W] && (w_wrap != '0)
                      && (w_wrap[TIME_W-1:0] <= r_cfg_gap);
    assign w_diff   = {1'b0, r_last_dist} - {1'b0, r_smp_dist};

    // The rise is the distance drop times 15360, taken as times 15 here and
    // shifted by ten bits at the compare.
    assign w_diff_ext = {{(RISE_W-DIST_W-1){r_diff[DIST_W]}}, r_diff};
    assign w_x15      = (w_diff_ext << 4) - w_diff_ext;

    assign w_qual = r_gap_ok && !r_rise15[RISE_W-1]
                    && ({3'b000, r_rise15[RISE_W-2:0], 10'b0} >= r_limit);

    always_comb begin
        n_rise_cnt  = r_rise_cnt;
        n_quiet_cnt = r_quiet_cnt;
        n_fast      = r_fast;
        w_quiet_inc = r_quiet_cnt + 8'd1;
        if (r_gap_ok) begin
            if (w_qual) begin
                n_quiet_cnt = '0;
                if (r_rise_cnt < r_cfg_confirm) begin
                    n_rise_cnt = r_rise_cnt + 4'd1;
                end
                if (!r_fast && (n_rise_cnt >= r_cfg_confirm)) begin
                    n_fast = 1'b1;
                end
            end else begin
                n_rise_cnt = '0;
                if (r_fast) begin
                    if (w_quiet_inc >= r_cfg_hold) begin
                        n_fast      = 1'b0;
                        n_quiet_cnt = '0;
                    end else begin
                        n_quiet_cnt = w_quiet_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_smp_dist <= i_dist_mm;
            r_smp_ok   <= i_read_ok;
            r_smp_time <= i_time_s;
        end
        if (i_cmd.gap) begin
            r_gap_ok  <= w_in_gap;
            r_elapsed <= w_wrap[TIME_W-1:0];
            r_diff    <= w_diff;
        end
        if (i_cmd.mult) begin
            r_limit  <= LIMIT_W'(r_cfg_thr) * LIMIT_W'(r_elapsed);
            r_rise15 <= w_x15;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dist <= '0;
            r_last_time <= '0;
            r_have_last <= 1'b0;
            r_rise_cnt  <= '0;
            r_quiet_cnt <= '0;
            r_fast      <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rise_cnt  <= n_rise_cnt;
            r_quiet_cnt <= n_quiet_cnt;
            r_fast      <= n_fast;
            if (r_smp_ok) begin
                r_last_dist <= r_smp_dist;
                r_last_time <= r_smp_time;
                r_have_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_fast <= n_fast;
            r_out_eval <= r_gap_ok;
            r_out_qual <= w_qual;
            r_out_chg  <= n_fast != r_fast;
            r_out_ivl  <= n_fast ? r_cfg_fast_ivl : r_cfg_norm_ivl;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_fast_mode      = r_out_fast;
    assign o_rate_evaluated = r_out_eval;
    assign o_rate_qualifies = r_out_qual;
    assign o_mode_changed   = r_out_chg;
    assign o_interval_s     = r_out_ivl;

endmodule

`default_nettype wire

// ===== src/rate_of_rise_cadence_detector_core.sv =====
// A report is registered at the commit step, after the gap check and threshold multiply
// steps of its sample. A new sample is accepted only after the controller's pass through
// gap check, threshold multiply and commit; a stalled report holds the commit step.
// A new sample is taken while the previous report still waits to be taken.
// Synchronous active-low reset clears the mode state and the last sample and
// loads the register defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// Rise-rate cadence detector core
// Selects normal or fast report cadence from the rise rate of water level.
// ----------------------------------------------------------------------------
module rate_of_rise_cadence_detector_core #(
    parameter int DAY_SECONDS = 86400
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    rrcd_in_if.sink                             i_sample,
    rrcd_out_if.source                          o_report,
    input  wire logic                           i_cfg_we,
    input  wire logic [rrcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rrcd_pkg::CFG_W-1:0]     i_cfg_data
);
    import rrcd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rrcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rrcd_dp #(
        .DAY_SECONDS (DAY_SECONDS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_dist_mm        (i_sample.dist_mm),
        .i_read_ok        (i_sample.read_ok),
        .i_time_s         (i_sample.time_s),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_report.valid),
        .i_ready          (o_report.ready),
        .o_fast_mode      (o_report.fast_mode),
        .o_rate_evaluated (o_report.rate_evaluated),
        .o_rate_qualifies (o_report.rate_qualifies),
        .o_mode_changed   (o_report.mode_changed),
        .o_interval_s     (o_report.interval_s)
    );

endmodule

`default_nettype wire

// ===== src/rrcd_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rise-rate cadence detector checker
// Port-level assertions on the sample and report channels, bound to the core.
// ----------------------------------------------------------------------------
module rrcd_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_eval,
    input wire logic        i_out_qual,
    input wire logic        i_out_chg,
    input wire logic [15:0] i_out_ivl
);

    // A stalled report beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_ivl) && $stable(i_out_chg))
        else $error("report beat changed while stalled");

    // Reset leaves no report pending.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("report valid right after reset");

    // A qualifying rate can only come from an evaluated one.
    a_qual_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_qual |-> i_out_eval)
        else $error("rate qualifies without evaluation");

    // The mode only moves on a sample that formed a rate.
    a_chg_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_eval |-> !i_out_chg)
        else $error("mode changed without a rate");

    // One sample is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample accepted while busy");

endmodule

bind rate_of_rise_cadence_detector_core rrcd_chk u_rrcd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_report.valid),
    .i_out_ready (o_report.ready),
    .i_out_eval  (o_report.rate_evaluated),
    .i_out_qual  (o_report.rate_qualifies),
    .i_out_chg   (o_report.mode_changed),
    .i_out_ivl   (o_report.interval_s)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rise-rate cadence detector testbench
// Drives distance samples through the sample channel, predicts each mode
// report in the bench and checks every report beat field by field. A short
// table of directed samples runs on the reset register values, followed by
// random phases that each reprogram all registers while the core is idle.
// ----------------------------------------------------------------------------
module tb;

    import rrcd_pkg::*;

    localparam int     DAY_SECONDS     = 86400;
    localparam longint RISE_SCALE      = 60 * 256;
    localparam int     NUM_PHASES      = 12;
    localparam int     ITEMS_PER_PHASE = 121;
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     WATCHDOG_LIMIT  = 4000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [DIST_W-1:0] dist_mm;
        logic              read_ok;
        logic [TIME_W-1:0] time_s;
    } t_sample;

    typedef struct packed {
        logic             fast_mode;
        logic             rate_evaluated;
        logic             rate_qualifies;
        logic             mode_changed;
        logic [IVL_W-1:0] interval_s;
    } t_report;

    typedef struct packed {
        t_sample item;
        logic    typed;
        t_report want;
    } t_dir_row;

    // Report with no rate formed while still in normal mode on reset registers.
    localparam t_report NORMAL_AT_RESET = '{1'b0, 1'b0, 1'b0, 1'b0, RST_NORMAL_IVL};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    rrcd_in_if  sample_ch ();
    rrcd_out_if report_ch ();

    rate_of_rise_cadence_detector_core #(
        .DAY_SECONDS(DAY_SECONDS)
    ) DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_sample  (sample_ch),
        .o_report  (report_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Register copies and detector state of the bench's own model.
    logic [THR_W-1:0]     thr_q8;
    logic [CONFIRM_W-1:0] confirm_need;
    logic [HOLD_W-1:0]    hold_need;
    logic [TIME_W-1:0]    gap_limit;
    logic [IVL_W-1:0]     ivl_normal;
    logic [IVL_W-1:0]     ivl_fast;
    logic [DIST_W-1:0]    prev_dist;
    logic [TIME_W-1:0]    prev_time;
    logic                 have_prev;
    logic [CONFIRM_W-1:0] rise_run;
    logic [HOLD_W-1:0]    quiet_run;
    logic                 in_fast;

    t_report expected_reports[$];
    int      mismatches   = 0;
    int      reports_seen = 0;
    bit      src_calm     = 1'b0;

    function automatic t_report predict_report(input t_sample s);
        t_report r;
        longint  elapsed;
        longint  rise;
        longint  limit;
        logic    was_fast;
        logic    evaluated;
        logic    qualifies;
        was_fast  = in_fast;
        evaluated = 1'b0;
        qualifies = 1'b0;
        if (s.read_ok) begin
            if (have_prev) begin
                elapsed = longint'(s.time_s) - longint'(prev_time);
                if (elapsed < 0) begin
                    elapsed += DAY_SECONDS;
                end
                if (elapsed > 0 && elapsed <= longint'(gap_limit)) begin
                    // Distance shrinks as the water rises, so the rise is old minus new.
                    rise      = (longint'(prev_dist) - longint'(s.dist_mm)) * RISE_SCALE;
                    limit     = longint'(thr_q8) * elapsed;
                    evaluated = 1'b1;
                    qualifies = (rise >= limit);
                    if (qualifies) begin
                        quiet_run = '0;
                        if (rise_run < confirm_need) begin
                            rise_run = rise_run + 1'b1;
                        end
                        if (!in_fast && rise_run >= confirm_need) begin
                            in_fast = 1'b1;
                        end
                    end else begin
                        rise_run = '0;
                        if (in_fast) begin
                            quiet_run = quiet_run + 1'b1;
                            if (quiet_run >= hold_need) begin
                                in_fast   = 1'b0;
                                quiet_run = '0;
                            end
                        end
                    end
                end
            end
            prev_dist = s.dist_mm;
            prev_time = s.time_s;
            have_prev = 1'b1;
        end
        r.fast_mode      = in_fast;
        r.rate_evaluated = evaluated;
        r.rate_qualifies = qualifies;
        r.mode_changed   = (in_fast != was_fast);
        r.interval_s     = in_fast ? ivl_fast : ivl_normal;
        return r;
    endfunction

    function automatic t_dir_row dir_row(input logic [DIST_W-1:0] d, input logic ok,
                                         input logic [TIME_W-1:0] t, input bit typed = 1'b0);
        t_dir_row row;
        row.item  = '{d, ok, t};
        row.typed = typed;
        row.want  = typed ? NORMAL_AT_RESET : '0;
        return row;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Register write on the port plus the same update in the model copy.
    // Bits above the register width are sometimes set; the core drops them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int width);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        if (width < CFG_W && $urandom_range(0, 3) == 0) begin
            data = data | CFG_W'($urandom() << width);
        end
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_RISE_THRESHOLD: thr_q8       = data[THR_W-1:0];
            CFG_CONFIRM_COUNT:  confirm_need = data[CONFIRM_W-1:0];
            CFG_HOLD_COUNT:     hold_need    = data[HOLD_W-1:0];
            CFG_MAX_GAP:        gap_limit    = data[TIME_W-1:0];
            CFG_NORMAL_IVL:     ivl_normal   = data[IVL_W-1:0];
            CFG_FAST_IVL:       ivl_fast     = data[IVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int unsigned thr, input int unsigned conf,
                                input int unsigned hold, input int unsigned gap,
                                input int unsigned nrm, input int unsigned fst,
                                input bit odd_phase);
        write_reg(CFG_RISE_THRESHOLD, thr, THR_W);
        write_reg(CFG_CONFIRM_COUNT, conf, CONFIRM_W);
        write_reg(CFG_HOLD_COUNT, hold, HOLD_W);
        write_reg(CFG_MAX_GAP, gap, TIME_W);
        write_reg(CFG_NORMAL_IVL, nrm, IVL_W);
        write_reg(CFG_FAST_IVL, fst, IVL_W);
        write_reg(odd_phase ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO, $urandom(), 0);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input t_sample s, input bit typed, input t_report typed_rpt);
        int      gap;
        t_report want;
        gap = src_calm ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.dist_mm <= s.dist_mm;
        sample_ch.read_ok <= s.read_ok;
        sample_ch.time_s  <= s.time_s;
        do @(posedge clk); while (!sample_ch.ready);
        want = predict_report(s);
        expected_reports.push_back(typed ? typed_rpt : want);
        if ($urandom_range(0, 39) == 0) begin
            src_calm = !src_calm;
        end
    endtask

    // Holds the sender off until every pending report has been taken.
    task automatic drain_reports();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : report_sink
        int stall;
        bit calm;
        calm            = 1'b0;
        report_ch.ready = 1'b0;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 14);
            @(negedge clk);
            if (stall > 0) begin
                report_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge clk); while (!(report_ch.valid === 1'b1 && rst_n));
            if ($urandom_range(0, 39) == 0) begin
                calm = !calm;
            end
        end
    end

    always @(posedge clk) begin : check_reports
        t_report want;
        if (rst_n && report_ch.valid && report_ch.ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("report beat %0d with no sample pending", reports_seen));
            end else begin
                want = expected_reports.pop_front();
                if (report_ch.fast_mode !== want.fast_mode)
                    report_mismatch($sformatf("beat %0d fast_mode %b, expected %b",
                        reports_seen, report_ch.fast_mode, want.fast_mode));
                if (report_ch.rate_evaluated !== want.rate_evaluated)
                    report_mismatch($sformatf("beat %0d rate_evaluated %b, expected %b",
                        reports_seen, report_ch.rate_evaluated, want.rate_evaluated));
                if (report_ch.rate_qualifies !== want.rate_qualifies)
                    report_mismatch($sformatf("beat %0d rate_qualifies %b, expected %b",
                        reports_seen, report_ch.rate_qualifies, want.rate_qualifies));
                if (report_ch.mode_changed !== want.mode_changed)
                    report_mismatch($sformatf("beat %0d mode_changed %b, expected %b",
                        reports_seen, report_ch.mode_changed, want.mode_changed));
                if (report_ch.interval_s !== want.interval_s)
                    report_mismatch($sformatf("beat %0d interval_s %0d, expected %0d",
                        reports_seen, report_ch.interval_s, want.interval_s));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        int idle_cycles;
        if (!rst_n) begin
            idle_cycles = 0;
        end else if ((sample_ch.valid && sample_ch.ready) ||
                     (report_ch.valid && report_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("rate_of_rise_cadence_detector_core test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_dir_row    dir_rows[$];
        t_sample     s;
        longint      cur_dist;
        longint      cur_time;
        longint      step;
        longint      need;
        longint      delta;
        int          pick;
        int          spell;
        bit          rising;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_RISE_THRESHOLD;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.dist_mm = '0;
        sample_ch.read_ok = 1'b0;
        sample_ch.time_s  = '0;

        thr_q8       = RST_RISE_THRESHOLD;
        confirm_need = RST_CONFIRM_COUNT;
        hold_need    = RST_HOLD_COUNT;
        gap_limit    = RST_MAX_GAP;
        ivl_normal   = RST_NORMAL_IVL;
        ivl_fast     = RST_FAST_IVL;
        prev_dist    = '0;
        prev_time    = '0;
        have_prev    = 1'b0;
        rise_run     = '0;
        quiet_run    = '0;
        in_fast      = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed samples on the reset register values.
        dir_rows = '{
            dir_row(16'hFFFF, 1'b0, 17'd131071, 1'b1), // failed read before any sample
            dir_row(16'd1000, 1'b1, 17'd100, 1'b1),    // first sample only stored
            dir_row(16'd900,  1'b1, 17'd110),          // first qualifying rise
            dir_row(16'd800,  1'b1, 17'd120),          // confirmed, enters fast mode
            dir_row(16'd0,    1'b0, 17'd0),            // failed read in fast mode
            dir_row(16'd700,  1'b1, 17'd120),          // zero elapsed time
            dir_row(16'd650,  1'b1, 17'd421),          // one second over the gap limit
            dir_row(16'd650,  1'b1, 17'd721),          // gap exactly at the limit, flat
            dir_row(16'd651,  1'b1, 17'd722),          // falling water level
            dir_row(16'd650,  1'b1, 17'd842),          // rise exactly at the threshold
            dir_row(16'd649,  1'b1, 17'd963),          // just below the threshold
            dir_row(16'hFFFF, 1'b1, 17'd86399),        // last second of the day
            dir_row(16'd0,    1'b1, 17'd10),           // elapsed wraps past midnight
            dir_row(16'd0,    1'b1, 17'd131071),       // time stamp beyond one day
            dir_row(16'd0,    1'b1, 17'd0),            // elapsed negative after wrap
            dir_row(16'd0,    1'b1, 17'd1),            // quiet samples leave fast mode
            dir_row(16'd0,    1'b1, 17'd2),
            dir_row(16'd0,    1'b1, 17'd3),
            dir_row(16'd0,    1'b1, 17'd4),
            dir_row(16'd0,    1'b1, 17'd5),
            dir_row(16'd0,    1'b1, 17'd6),
            dir_row(16'd0,    1'b1, 17'd7),
            dir_row(16'd0,    1'b1, 17'd8),
            dir_row(16'd0,    1'b1, 17'd9),
            dir_row(16'd0,    1'b1, 17'd10)
        };
        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_reports();

        cur_dist = 40000;
        cur_time = 0;
        spell    = 0;
        rising   = 1'b0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: program_regs(0, 0, 0, 1, 0, 65535, phase[0]);
                1: program_regs(65535, 15, 255, 131071, 65535, 0, phase[0]);
                2: program_regs($urandom_range(0, 2000), $urandom_range(1, 4),
                                $urandom_range(1, 10), 0, 60, 5, phase[0]);
                3: program_regs(128, 1, 1, 86399, 1, 1, phase[0]);
                default: program_regs($urandom_range(0, 65535), $urandom_range(0, 15),
                                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(1, 24),
                                      ($urandom_range(0, 1) == 0) ? $urandom_range(1, 600)
                                                                 : $urandom_range(1, 86399),
                                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                                      phase[0]);
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    s = '{DIST_W'($urandom()), 1'b0, TIME_W'($urandom_range(0, 131071))};
                end else if (pick < 14) begin
                    // Out-of-sequence reading: any distance at any time stamp.
                    cur_dist = $urandom_range(0, 65535);
                    cur_time = $urandom_range(0, 131071);
                    s = '{DIST_W'(cur_dist), 1'b1, TIME_W'(cur_time)};
                end else begin
                    if (gap_limit == 0) begin
                        step = $urandom_range(0, 20);
                    end else begin
                        step = $urandom_range(1, (gap_limit > 900) ? 900 : gap_limit);
                        if ($urandom_range(0, 7) == 0) begin
                            step = longint'(gap_limit) + $urandom_range(0, 1);
                        end
                    end
                    // Smallest distance drop that meets the threshold over this step.
                    need = (longint'(thr_q8) * step + RISE_SCALE - 1) / RISE_SCALE;
                    if (spell == 0) begin
                        rising = $urandom_range(0, 1);
                        spell  = $urandom_range(1, 24);
                    end
                    spell--;
                    if ($urandom_range(0, 5) == 0) begin
                        delta = need - $urandom_range(0, 1);
                    end else if (rising) begin
                        delta = need + $urandom_range(0, 2);
                    end else begin
                        delta = need - 1 - $urandom_range(0, 2);
                    end
                    cur_dist = cur_dist - delta;
                    if (cur_dist < 0 || cur_dist > 65535) begin
                        cur_dist = $urandom_range(0, 65535);
                    end
                    cur_time = cur_time + step;
                    if (cur_time >= DAY_SECONDS) begin
                        cur_time -= DAY_SECONDS;
                    end
                    cur_time = cur_time % (longint'(1) << TIME_W);
                    s = '{DIST_W'(cur_dist), 1'b1, TIME_W'(cur_time)};
                end
                send_sample(s, 1'b0, '0);
                if ($urandom_range(0, 199) == 0) begin
                    drain_reports();
                end
            end
            drain_reports();
        end

        if (mismatches == 0) begin
            $display("rate_of_rise_cadence_detector_core test passed");
        end else begin
            $display("rate_of_rise_cadence_detector_core test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rrcd_pkg.sv
src/rrcd_in_if.sv
src/rrcd_out_if.sv
src/rrcd_ctrl.sv
src/rrcd_dp.sv
src/rate_of_rise_cadence_detector_core.sv
src/rrcd_chk.sv
verif/tb.sv
